FILE: src/ests_pkg.sv
// ests_pkg: shared types and constants of the endpoint session table.
// No dependencies.
package ests_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W = 5;
	localparam int REM_W = 16;
	localparam int REM_CW = $clog2(REM_W + 1);

	typedef enum logic [2:0] {
		OP_UPSERT = 3'd0,
		OP_FIND   = 3'd1,
		OP_PROBE  = 3'd2,
		OP_EXPIRE = 3'd3,
		OP_DELETE = 3'd4,
		OP_CLEAR  = 3'd5,
		OP_RSVD6  = 3'd6,
		OP_RSVD7  = 3'd7
	} op_t;

	typedef logic [1:0] stat_t;
	localparam stat_t ST_OK   = 2'd0;
	localparam stat_t ST_NF   = 2'd1;
	localparam stat_t ST_FULL = 2'd2;
	localparam stat_t ST_BAD  = 2'd3;

	localparam logic [1:0] CFG_PORT_STEP = 2'd0;
	localparam logic [1:0] CFG_PORT_TRIES = 2'd1;
	localparam logic [1:0] CFG_RETRY_WINDOW = 2'd2;
	localparam logic [1:0] CFG_MAX_AGE = 2'd3;

	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] seen;
		logic [15:0] ping;
	} ent_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_REMW,
		S_UPD,
		S_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic rd;
		logic eval;
		logic rem_start;
		logic rem_eval;
		logic upd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic upsert_go;
		logic cand;
		logic rem_busy;
		logic out_free;
	} sts_t;

endpackage

FILE: src/ests_rem.sv
// ests_rem: bit-serial restoring remainder, one dividend bit per cycle.
// Depends on ests_pkg.
module ests_rem
	import ests_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [REM_W-1:0] dividend,
	input  logic [REM_W-1:0] divisor,
	output logic             busy,
	output logic             rem_zero
);

	logic [REM_W:0]   r_q;
	logic [REM_W-1:0] d_q;
	logic [REM_W-1:0] div_q;
	logic [REM_CW-1:0] cnt_q;
	logic [REM_W:0]   r_sh;

	assign r_sh = {r_q[REM_W-1:0], d_q[REM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= REM_CW'(REM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			d_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			d_q <= {d_q[REM_W-2:0], 1'b0};
			if (r_sh >= {1'b0, div_q}) begin
				r_q <= r_sh - {1'b0, div_q};
			end else begin
				r_q <= r_sh;
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign rem_zero = (r_q == '0);

endmodule

FILE: src/ests_dp.sv
// ests_dp: entry memory, request and config registers, compare logic, result words.
// Depends on ests_pkg and ests_rem.
module ests_dp
	import ests_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata,
	input  logic [2:0]   opcode,
	input  logic [31:0]  ip_addr,
	input  logic [15:0]  port_num,
	input  logic [31:0]  now_time,
	input  logic [15:0]  ping_sample,
	input  logic [4:0]   slot_sel,
	input  logic         out_ready,
	output logic         out_valid,
	output logic [1:0]   status,
	output logic [4:0]   slot,
	output logic         created,
	output logic         recent,
	output logic [5:0]   used_entries,
	output logic [5:0]   removed
);

	ent_t mem [TABLE_DEPTH];

	logic [15:0] step_q, tries_q;
	logic [31:0] window_q, max_age_q;

	op_t         op_q;
	logic [31:0] ip_q, now_q, limit_q;
	logic [15:0] port_q, ping_q;
	logic [4:0]  sel_q;
	logic [CNT_W-1:0] fill_q, idx_q, wr_q, rmv_q;
	logic [IDX_W-1:0] cur_q, slot_q;
	logic hit_q, recent_q, created_q, ovalid_q;
	ent_t rd_s1;

	logic        match_key, pre, drop, bad, rem_zero, rem_busy;
	logic        we;
	logic [IDX_W-1:0] waddr;
	ent_t        wdata;
	logic [15:0] diff;
	logic [31:0] age;
	logic [17:0] smooth;
	logic [CNT_W-1:0] fill_nxt;
	stat_t       st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 16'd1;
			tries_q <= 16'd1;
			window_q <= 32'd0;
			max_age_q <= 32'd60;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PORT_STEP: step_q <= cfg_wdata[15:0];
				CFG_PORT_TRIES: tries_q <= cfg_wdata[15:0];
				CFG_RETRY_WINDOW: window_q <= cfg_wdata;
				CFG_MAX_AGE: max_age_q <= cfg_wdata;
			endcase
		end
	end

	assign match_key = (rd_s1.ip == ip_q) && (rd_s1.port == port_q);
	assign diff = rd_s1.port - port_q;
	assign pre = (rd_s1.ip == ip_q) && (rd_s1.port >= port_q) && ({16'd0, diff} < limit_q);
	assign age = now_q - rd_s1.seen;
	assign drop = (op_q == OP_EXPIRE) ? (age > max_age_q) : (cur_q == sel_q[IDX_W-1:0]);
	assign bad = ({1'b0, sel_q} >= fill_q);
	assign smooth = 18'(3 * rd_s1.ping) + 18'(ping_q) + 18'd2;

	always_comb begin
		sts.scan_end = hit_q || (idx_q >= fill_q) || (op_q == OP_CLEAR) ||
			(op_q == OP_RSVD6) || (op_q == OP_RSVD7) || ((op_q == OP_DELETE) && bad);
		sts.upsert_go = (op_q == OP_UPSERT) && (hit_q || (fill_q < CNT_W'(TABLE_DEPTH)));
		sts.cand = (op_q == OP_PROBE) && pre;
		sts.rem_busy = rem_busy;
		sts.out_free = !ovalid_q || out_ready;
	end

	always_comb begin
		we = 1'b0;
		waddr = wr_q[IDX_W-1:0];
		wdata = rd_s1;
		if (cmd.eval && ((op_q == OP_EXPIRE) || (op_q == OP_DELETE)) && !drop) begin
			we = 1'b1;
		end else if (cmd.upd) begin
			we = 1'b1;
			waddr = hit_q ? slot_q : fill_q[IDX_W-1:0];
			wdata.ip = ip_q;
			wdata.port = port_q;
			wdata.seen = now_q;
			wdata.ping = hit_q ? smooth[17:2] : ping_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	ests_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rem_start),
		.dividend (diff),
		.divisor  (step_q),
		.busy     (rem_busy),
		.rem_zero (rem_zero)
	);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= op_t'(opcode);
			ip_q <= ip_addr;
			port_q <= port_num;
			now_q <= now_time;
			ping_q <= ping_sample;
			sel_q <= slot_sel;
			limit_q <= 32'(tries_q) * 32'(step_q);
			idx_q <= '0;
			wr_q <= '0;
			rmv_q <= '0;
			hit_q <= 1'b0;
			slot_q <= '0;
			recent_q <= 1'b0;
			created_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				cur_q <= idx_q[IDX_W-1:0];
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.eval) begin
				if (((op_q == OP_UPSERT) || (op_q == OP_FIND)) && match_key) begin
					hit_q <= 1'b1;
					slot_q <= cur_q;
				end
				if ((op_q == OP_EXPIRE) || (op_q == OP_DELETE)) begin
					if (drop) begin
						rmv_q <= rmv_q + 1'b1;
					end else begin
						wr_q <= wr_q + 1'b1;
					end
				end
			end
			if (cmd.rem_eval && rem_zero) begin
				hit_q <= 1'b1;
				slot_q <= cur_q;
				recent_q <= (age < window_q);
			end
			if (cmd.upd && !hit_q) begin
				slot_q <= fill_q[IDX_W-1:0];
				created_q <= 1'b1;
			end
		end
	end

	always_comb begin
		fill_nxt = fill_q;
		st_nxt = ST_OK;
		unique case (op_q)
			OP_UPSERT: st_nxt = (hit_q || created_q) ? ST_OK : ST_FULL;
			OP_FIND, OP_PROBE: st_nxt = hit_q ? ST_OK : ST_NF;
			OP_EXPIRE: fill_nxt = wr_q;
			OP_DELETE: begin
				if (bad) begin
					st_nxt = ST_BAD;
				end else begin
					fill_nxt = wr_q;
				end
			end
			OP_CLEAR: fill_nxt = '0;
			OP_RSVD6, OP_RSVD7: st_nxt = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.upd && !hit_q) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.finish) begin
				fill_q <= fill_nxt;
			end
			if (cmd.finish) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status <= st_nxt;
			slot <= SLOT_W'(slot_q);
			created <= created_q;
			recent <= recent_q;
			used_entries <= 6'(fill_nxt);
			removed <= (op_q == OP_CLEAR) ? 6'(fill_q) : 6'(rmv_q);
		end
	end

	assign out_valid = ovalid_q;

endmodule

FILE: src/ests_ctrl.sv
// ests_ctrl: request sequencer; steps the entry scan and the result handoff.
// Depends on ests_pkg.
module ests_ctrl
	import ests_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_READ;
			S_READ: begin
				if (!sts.scan_end) begin
					state_nxt = S_EVAL;
				end else if (sts.upsert_go) begin
					state_nxt = S_UPD;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_EVAL: state_nxt = sts.cand ? S_REMW : S_READ;
			S_REMW: if (!sts.rem_busy) state_nxt = S_READ;
			S_UPD: state_nxt = S_FIN;
			S_FIN: if (sts.out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.start = in_valid;
			end
			S_READ: cmd.rd = !sts.scan_end;
			S_EVAL: begin
				cmd.eval = !sts.cand;
				cmd.rem_start = sts.cand;
			end
			S_REMW: cmd.rem_eval = !sts.rem_busy;
			S_UPD: cmd.upd = 1'b1;
			S_FIN: cmd.finish = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: src/endpoint_session_table.sv
// endpoint_session_table: top level of the ordered endpoint table.
// Depends on ests_pkg, ests_ctrl, ests_dp.
//
//   channel  handshake             word
//   in       in_valid / in_ready   opcode ip_addr port_num now_time ping_sample slot_sel
//   out      out_valid / out_ready status slot created recent used_entries removed
//   cfg      cfg_we                cfg_idx cfg_wdata
//
// One request at a time; each probe entry in the port range runs the serial remainder.
// The entry memory is single-ported.
// Reset clears the fill count and sets the config to its defaults; the table needs no clearing pass.
// A waiting result sits in the output register; the next request may already run.
module endpoint_session_table
	import ests_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] ip_addr,
	input  logic [15:0] port_num,
	input  logic [31:0] now_time,
	input  logic [15:0] ping_sample,
	input  logic [4:0]  slot_sel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [4:0]  slot,
	output logic        created,
	output logic        recent,
	output logic [5:0]  used_entries,
	output logic [5:0]  removed
);

	cmd_t cmd;
	sts_t sts;

	ests_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ests_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.opcode       (opcode),
		.ip_addr      (ip_addr),
		.port_num     (port_num),
		.now_time     (now_time),
		.ping_sample  (ping_sample),
		.slot_sel     (slot_sel),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.slot         (slot),
		.created      (created),
		.recent       (recent),
		.used_entries (used_entries),
		.removed      (removed)
	);

endmodule

FILE: tb/sv/endpoint_session_table_test.sv
// endpoint_session_table_test: self-checking bench for the endpoint session table.
// Predicts each result word from a behavioral copy of the table; depends on ests_pkg.
`timescale 1ns / 100ps
module endpoint_session_table_test;
	import ests_pkg::*;

	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] slot;
		logic       created;
		logic       recent;
		logic [5:0] used_entries;
		logic [5:0] removed;
	} res_t;

	logic clk = 0, arst_n = 1;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 0, in_ready;
	logic [2:0] opcode = '0;
	logic [31:0] ip_addr = '0;
	logic [15:0] port_num = '0;
	logic [31:0] now_time = '0;
	logic [15:0] ping_sample = '0;
	logic [4:0] slot_sel = '0;
	logic out_valid, out_ready = 0;
	logic [1:0] status;
	logic [4:0] slot;
	logic created, recent;
	logic [5:0] used_entries, removed;

	endpoint_session_table u_top (.*);

	initial forever #5 clk = ~clk;

	// shadow table
	logic [15:0] m_step = 1, m_tries = 1;
	logic [31:0] m_window = 0, m_age = 60;
	logic [31:0] t_ip [TABLE_DEPTH];
	logic [15:0] t_port [TABLE_DEPTH];
	logic [31:0] t_seen [TABLE_DEPTH];
	logic [15:0] t_ping [TABLE_DEPTH];
	int t_fill = 0;

	res_t expected_q[$];
	int errors = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int hold_cycles = 0;
	int quiet = 0;
	logic [31:0] clock_now = 1000;

	task automatic report(string what, logic [31:0] got, logic [31:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	function automatic int find_entry(logic [31:0] ip, logic [15:0] port);
		for (int i = 0; i < t_fill; i++)
			if (t_ip[i] == ip && t_port[i] == port) return i;
		return -1;
	endfunction

	function automatic void drop_entry(int k);
		t_fill--;
		for (int i = k; i < t_fill; i++) begin
			t_ip[i] = t_ip[i+1]; t_port[i] = t_port[i+1];
			t_seen[i] = t_seen[i+1]; t_ping[i] = t_ping[i+1];
		end
	endfunction

	function automatic res_t session_result(op_t op, logic [31:0] ip, logic [15:0] port,
			logic [31:0] now, logic [15:0] ping, logic [4:0] sel);
		res_t r;
		int k, i;
		logic [16:0] sm;
		longint lim;
		r = '0;
		case (op)
		OP_UPSERT: begin
			k = find_entry(ip, port);
			if (k < 0 && t_fill >= TABLE_DEPTH) r.status = ST_FULL;
			else begin
				if (k < 0) begin
					k = t_fill++;
					t_ip[k] = ip; t_port[k] = port; t_ping[k] = ping;
					r.created = 1;
				end
				t_seen[k] = now;
				sm = 17'((3 * 32'(t_ping[k]) + 32'(ping) + 32'd2) >> 2);
				t_ping[k] = sm[15:0];
				r.slot = 5'(k);
			end
		end
		OP_FIND: begin
			k = find_entry(ip, port);
			if (k < 0) r.status = ST_NF; else r.slot = 5'(k);
		end
		OP_PROBE: begin
			lim = longint'(port) + longint'(m_tries) * longint'(m_step);
			r.status = ST_NF;
			if (m_step != 0)
				for (i = 0; i < t_fill; i++)
					if (t_ip[i] == ip && t_port[i] >= port && longint'(t_port[i]) < lim &&
							(t_port[i] - port) % m_step == 0) begin
						r.status = ST_OK;
						r.slot = 5'(i);
						r.recent = (now - t_seen[i]) < m_window;
						break;
					end
		end
		OP_EXPIRE: begin
			i = 0;
			while (i < t_fill)
				if ((now - t_seen[i]) > m_age) begin
					drop_entry(i); r.removed++;
				end else i++;
		end
		OP_DELETE: begin
			if (sel >= t_fill) r.status = ST_BAD;
			else begin
				drop_entry(sel); r.removed = 1;
			end
		end
		OP_CLEAR: begin
			r.removed = 6'(t_fill); t_fill = 0;
		end
		default: ;
		endcase
		r.used_entries = 6'(t_fill);
		return r;
	endfunction

	task automatic send_word(op_t op, logic [31:0] ip, logic [15:0] port, logic [31:0] now,
			logic [15:0] ping, logic [4:0] sel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		expected_q.push_back(session_result(op, ip, port, now, ping, sel));
		in_valid <= 1; opcode <= op; ip_addr <= ip; port_num <= port;
		now_time <= now; ping_sample <= ping; slot_sel <= sel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
		@(posedge clk);
		case (idx)
		CFG_PORT_STEP: m_step = val[15:0];
		CFG_PORT_TRIES: m_tries = val[15:0];
		CFG_RETRY_WINDOW: m_window = val;
		default: m_age = val;
		endcase
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// receiver
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		res_t e;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) report("unexpected word", 32'(status), 0);
			else begin
				e = expected_q.pop_front();
				if (status !== e.status) report("status", 32'(status), 32'(e.status));
				if (slot !== e.slot) report("slot", 32'(slot), 32'(e.slot));
				if (created !== e.created) report("created", 32'(created), 32'(e.created));
				if (recent !== e.recent) report("recent", 32'(recent), 32'(e.recent));
				if (used_entries !== e.used_entries)
					report("used_entries", 32'(used_entries), 32'(e.used_entries));
				if (removed !== e.removed) report("removed", 32'(removed), 32'(e.removed));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || expected_q.size() == 0)
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rand_ip();
		return ($urandom_range(3) == 0) ? $urandom() : 32'h0a000000 + $urandom_range(3);
	endfunction

	task automatic test_directed();
		send_word(OP_DELETE, 0, 0, 0, 0, 0);
		send_word(OP_EXPIRE, 0, 0, 0, 0, 0);
		send_word(OP_FIND, 32'hffffffff, 16'hffff, 0, 0, 0);
		send_word(OP_UPSERT, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 5'h1f);
		send_word(OP_UPSERT, 32'hffffffff, 16'hffff, 0, 0, 0);
		send_word(OP_UPSERT, 0, 0, 100, 16'h8000, 0);
		send_word(OP_UPSERT, 0, 1, 100, 7, 0);
		send_word(OP_FIND, 0, 1, 0, 0, 0);
		send_word(OP_PROBE, 0, 0, 100, 0, 0);
		send_word(OP_PROBE, 0, 5, 100, 0, 0);
		send_word(OP_DELETE, 0, 0, 0, 0, 5'd31);
		send_word(OP_DELETE, 0, 0, 0, 0, 5'd1);
		send_word(OP_RSVD6, 0, 0, 0, 0, 0);
		send_word(OP_RSVD7, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff, 5'h1f);
		send_word(OP_EXPIRE, 0, 0, 32'd50, 0, 0);
		send_word(OP_EXPIRE, 0, 0, 32'd200, 0, 0);
		for (int i = 0; i < 33; i++) send_word(OP_UPSERT, 32'(i), 16'(i), 5, 16'(i), 0);
		send_word(OP_CLEAR, 0, 0, 0, 0, 0);
		drain();
	endtask

	task automatic test_random(int n);
		op_t op;
		for (int i = 0; i < n; i++) begin
			clock_now += $urandom_range(20);
			case ($urandom_range(99)) inside
			[0:44]: op = OP_UPSERT;
			[45:59]: op = OP_FIND;
			[60:79]: op = OP_PROBE;
			[80:87]: op = OP_EXPIRE;
			[88:95]: op = OP_DELETE;
			[96:97]: op = OP_CLEAR;
			default: op = op_t'($urandom_range(7));
			endcase
			send_word(op, rand_ip(),
				($urandom_range(7) == 0) ? 16'($urandom()) : 16'(100 + $urandom_range(12)),
				($urandom_range(15) == 0) ? $urandom() : clock_now,
				16'($urandom()), 5'($urandom()));
		end
		drain();
	endtask

	task automatic test_config(logic [15:0] step, logic [15:0] tries, logic [31:0] win,
			logic [31:0] age, int n);
		write_reg(CFG_PORT_STEP, 32'(step));
		write_reg(CFG_PORT_TRIES, 32'(tries));
		write_reg(CFG_RETRY_WINDOW, win);
		write_reg(CFG_MAX_AGE, age);
		cfg_we <= 0;
		test_random(n);
	endtask

	task automatic test_backpressure();
		hold_cycles = 600;
		for (int i = 0; i < 12; i++)
			send_word(OP_UPSERT, rand_ip(), 16'(100 + i), clock_now, 16'($urandom()), 0);
		drain();
	endtask

	initial begin
		arst_n <= 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_config(1, 4, 30, 60, 200);
		send_idle_pct = 77;
		test_config(3, 3, 0, 0, 200);
		send_idle_pct = 0; recv_stall_pct = 77;
		test_config(16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff, 200);
		send_idle_pct = 10; recv_stall_pct = 10;
		test_config(0, 0, 10, 40, 200);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_config(2, 6, 25, 100, 400);
		test_backpressure();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end
endmodule
